// ===== rtl/gbt_pkg.sv =====
// Package: shared types and codes for the graph traversal engine.
package gbt_pkg;

  localparam int unsigned VertexW = 10;
  localparam int unsigned NumW    = 11;
  localparam int unsigned StatusW = 3;
  // Vertex count is bounded by the vertex field width.
  localparam int unsigned MaxVertices = 1024;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_START = 2'd1,
    REQ_FETCH = 2'd2,
    REQ_BAD   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_REJECT   = 3'd1,
    ST_FULL     = 3'd2,
    ST_FINISHED = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  localparam logic [0:0] CfgNumVertices  = 1'b0;
  localparam logic [0:0] CfgTraversalMode = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [VertexW-1:0] vertex_a;
    logic [VertexW-1:0] vertex_b;
  } req_t;

  typedef struct packed {
    logic [VertexW-1:0] vertex;
    logic [StatusW-1:0] status;
  } rsp_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic cap;        // capture request
    logic add_chk;    // latch degrees of both ends
    logic add_wr_a;   // write a's list, bump degree
    logic add_wr_b;   // write b's list, bump degree
    logic init_step;  // clear one degree count after reset
    logic clr_step;   // clear one visited mark
    logic start_seed; // seed work store
    logic pop_rd;     // read visited mark of popped vertex
    logic pop_take;   // take popped vertex
    logic nb_take;    // evaluate neighbour
    logic finish;     // traversal inactive
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic bad_range;
    logic list_full;
    logic start_bad;
    logic clr_done;
    logic mode_dfs;
    logic active;
    logic empty;
    logic cur_visited;
    logic nb_last;
  } sts_t;

endpackage

// ===== rtl/gbt_datapath.sv =====
// Datapath: adjacency, degree, visited and work memories with request registers.
module gbt_datapath #(
  parameter int unsigned MAX_DEGREE   = 8,
  parameter int unsigned WORK_DEPTH   = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gbt_pkg::req_t req_i,
  input  gbt_pkg::cmd_t cmd_i,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [10:0]   cfg_data_i,
  output gbt_pkg::sts_t sts_o,
  output gbt_pkg::rsp_t rsp_o
);
  import gbt_pkg::*;

  localparam int unsigned VIdxW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned DegW  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned SlotW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned AdjD  = MaxVertices * MAX_DEGREE;
  localparam int unsigned AdjW  = $clog2(AdjD);
  localparam int unsigned WIdxW = $clog2(WORK_DEPTH);
  localparam int unsigned WCntW = $clog2(WORK_DEPTH + 1);
  localparam int unsigned CmpW  = (VIdxW + 1 > NumW) ? VIdxW + 1 : NumW;

  logic [VertexW-1:0] adj_mem [AdjD];
  logic [DegW-1:0]    deg_mem [MaxVertices];
  logic               vis_mem [MaxVertices];
  logic [VertexW-1:0] work_mem [WORK_DEPTH];

  logic [NumW-1:0]    num_q;
  logic               mode_q, mode_l_q, active_q;
  req_t               req_q;
  logic [WCntW-1:0]   head_q, tail_q;
  logic [VIdxW-1:0]   clr_q;
  logic [DegW-1:0]    deg_a_q, deg_b_q, deg_rd_q;
  logic               vis_rd_q, over_q;
  logic [VertexW-1:0] work_rd_q, adj_rd_q, cur_q;
  logic [DegW-1:0]    k_q;
  logic [CmpW-1:0]    used, a_ext, b_ext;

  always_comb begin
    used = (CmpW'(num_q) > CmpW'(MaxVertices)) ? CmpW'(MaxVertices) : CmpW'(num_q);
    a_ext = CmpW'(req_q.vertex_a);
    b_ext = CmpW'(req_q.vertex_b);
  end

  logic [VIdxW-1:0] a_i, b_i, cur_i, nb_i;
  assign a_i   = req_q.vertex_a[VIdxW-1:0];
  assign b_i   = req_q.vertex_b[VIdxW-1:0];
  assign cur_i = cur_q[VIdxW-1:0];
  assign nb_i  = adj_rd_q[VIdxW-1:0];

  // Second degree read port: b end on add, popped vertex on fetch.
  logic [VIdxW-1:0] deg_ra;
  assign deg_ra = cmd_i.pop_take ? work_rd_q[VIdxW-1:0] : b_i;

  // Read address of work store: FIFO head or stack top.
  logic [WIdxW-1:0] work_ra;
  assign work_ra = mode_l_q ? WIdxW'(tail_q - 1'b1) : WIdxW'(head_q);
  // Neighbour slot: forward for BFS, reverse for DFS.
  logic [DegW-1:0] slot;
  assign slot = mode_l_q ? DegW'(deg_rd_q - k_q - 1'b1) : k_q;
  logic [AdjW-1:0] adj_ra;
  assign adj_ra = AdjW'(cur_i) * AdjW'(MAX_DEGREE) + AdjW'(slot[SlotW-1:0]);

  logic push_ok, nb_new;
  assign push_ok = tail_q < WCntW'(WORK_DEPTH);
  assign nb_new  = !vis_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q    <= '0;
      mode_q   <= 1'b0;
      mode_l_q <= 1'b0;
      active_q <= 1'b0;
      head_q   <= '0;
      tail_q   <= '0;
      clr_q    <= '0;
      k_q      <= '0;
      over_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgNumVertices) num_q <= cfg_data_i;
        else mode_q <= cfg_data_i[0];
      end
      if (cmd_i.cap) begin
        clr_q  <= '0;
        k_q    <= '0;
        over_q <= 1'b0;
      end
      if (cmd_i.clr_step || cmd_i.init_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.start_seed) begin
        head_q <= '0;
        if (sts_o.start_bad) begin
          tail_q   <= '0;
          active_q <= 1'b0;
        end else begin
          tail_q   <= WCntW'(1);
          active_q <= 1'b1;
          mode_l_q <= mode_q;
        end
      end
      if (cmd_i.pop_take) begin
        if (mode_l_q) tail_q <= tail_q - 1'b1;
        else head_q <= head_q + 1'b1;
      end
      if (cmd_i.nb_take) begin
        k_q <= k_q + 1'b1;
        if (nb_new) begin
          if (push_ok) tail_q <= tail_q + 1'b1;
          else over_q <= 1'b1;
        end
      end
      if (cmd_i.finish) active_q <= 1'b0;
    end
  end

  // Degree counts are swept to zero after reset; visited marks are swept on
  // every start and are never read before the first one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) req_q <= req_i;
    deg_a_q <= deg_mem[a_i];
    if (cmd_i.add_chk) deg_b_q <= deg_mem[deg_ra];
    if (cmd_i.init_step) deg_mem[clr_q] <= '0;
    if (cmd_i.add_wr_a) begin
      adj_mem[AdjW'(a_i) * AdjW'(MAX_DEGREE) + AdjW'(deg_a_q)] <= req_q.vertex_b;
      deg_mem[a_i] <= deg_a_q + 1'b1;
    end
    if (cmd_i.add_wr_b) begin
      adj_mem[AdjW'(b_i) * AdjW'(MAX_DEGREE) + AdjW'(deg_b_q)] <= req_q.vertex_a;
      deg_mem[b_i] <= deg_b_q + 1'b1;
    end
    if (cmd_i.clr_step) vis_mem[clr_q] <= 1'b0;
    if (cmd_i.start_seed && !sts_o.start_bad) begin
      work_mem[0] <= req_q.vertex_a;
      if (!mode_q) vis_mem[a_i] <= 1'b1;
    end
    work_rd_q <= work_mem[work_ra];
    if (cmd_i.pop_take) begin
      cur_q <= work_rd_q;
    end
    if (cmd_i.pop_rd) vis_rd_q <= vis_mem[work_rd_q[VIdxW-1:0]];
    else if (cmd_i.nb_take) vis_rd_q <= vis_rd_q;
    else vis_rd_q <= vis_mem[nb_i];
    if (cmd_i.pop_take) begin
      deg_rd_q <= deg_mem[deg_ra];
      if (mode_l_q) vis_mem[work_rd_q[VIdxW-1:0]] <= 1'b1;
    end
    adj_rd_q <= adj_mem[adj_ra];
    if (cmd_i.nb_take && nb_new && push_ok) begin
      work_mem[WIdxW'(tail_q)] <= adj_rd_q;
      if (!mode_l_q) vis_mem[nb_i] <= 1'b1;
    end
  end

  always_comb begin
    sts_o.bad_range   = (a_ext >= used) || (b_ext >= used) ||
                        (req_q.vertex_a == req_q.vertex_b);
    sts_o.list_full   = (deg_a_q >= DegW'(MAX_DEGREE)) || (deg_b_q >= DegW'(MAX_DEGREE));
    sts_o.start_bad   = a_ext >= used;
    sts_o.clr_done    = clr_q == VIdxW'(MaxVertices - 1);
    sts_o.mode_dfs    = mode_l_q;
    sts_o.active      = active_q;
    sts_o.empty       = mode_l_q ? (tail_q == '0) : (head_q >= tail_q);
    sts_o.cur_visited = vis_rd_q;
    sts_o.nb_last     = k_q >= deg_rd_q;
  end

  assign rsp_o.vertex = cur_q;
  assign rsp_o.status = over_q ? ST_OVERFLOW : ST_OK;
endmodule

// ===== rtl/gbt_ctrl.sv =====
// Controller: sequences add, start and fetch requests over the datapath.
module gbt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    req_type_i,
  input  gbt_pkg::sts_t sts_i,
  output logic          busy_o,
  output gbt_pkg::cmd_t cmd_o,
  output logic          done_o,
  output logic [2:0]    status_o,
  output logic          use_cur_o
);
  import gbt_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_ADD0   = 13'b0000000000010,
    S_ADD1   = 13'b0000000000100,
    S_ADD2   = 13'b0000000001000,
    S_CLR    = 13'b0000000010000,
    S_FETCH  = 13'b0000000100000,
    S_POP0   = 13'b0000001000000,
    S_POP1   = 13'b0000010000000,
    S_POP2   = 13'b0000100000000,
    S_NBA    = 13'b0001000000000,
    S_NBB    = 13'b0010000000000,
    S_NBC    = 13'b0100000000000,
    S_INIT   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] req_q;
  logic       accept;

  assign accept = start_i && !busy_o;
  assign busy_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      req_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) req_q <= req_type_i;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    done_o    = 1'b0;
    status_o  = ST_OK;
    use_cur_o = 1'b0;
    cmd_o.cap = accept;
    case (state_q)
      S_INIT: begin
        // degree counts cleared in turn after reset
        cmd_o.init_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_ADD:   state_d = S_ADD0;
            REQ_START: state_d = S_CLR;
            REQ_FETCH: state_d = S_FETCH;
            default:   state_d = S_ADD0;
          endcase
        end
      end
      S_ADD0: begin
        // degree of a reads registered; latch b now
        cmd_o.add_chk = 1'b1;
        state_d = S_ADD1;
      end
      S_ADD1: begin
        if (req_q != REQ_ADD) begin
          done_o = 1'b1; status_o = ST_REJECT; state_d = S_IDLE;
        end else if (sts_i.bad_range) begin
          done_o = 1'b1; status_o = ST_REJECT; state_d = S_IDLE;
        end else if (sts_i.list_full) begin
          done_o = 1'b1; status_o = ST_FULL; state_d = S_IDLE;
        end else begin
          cmd_o.add_wr_a = 1'b1; state_d = S_ADD2;
        end
      end
      S_ADD2: begin
        cmd_o.add_wr_b = 1'b1;
        done_o = 1'b1;
        state_d = S_IDLE;
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          cmd_o.clr_step = 1'b1;
          state_d = S_POP0;
        end
      end
      S_POP0: begin
        if (req_q == REQ_START) begin
          cmd_o.start_seed = 1'b1;
          done_o = 1'b1;
          status_o = sts_i.start_bad ? ST_REJECT : ST_OK;
          state_d = S_IDLE;
        end else begin
          // work store read address settles, data registered next cycle
          state_d = S_POP1;
        end
      end
      S_FETCH: begin
        if (!sts_i.active) begin
          done_o = 1'b1; status_o = ST_FINISHED; state_d = S_IDLE;
        end else if (sts_i.empty) begin
          cmd_o.finish = 1'b1;
          done_o = 1'b1; status_o = ST_FINISHED; state_d = S_IDLE;
        end else begin
          state_d = S_POP0;
        end
      end
      S_POP1: begin
        cmd_o.pop_rd = 1'b1;
        state_d = S_POP2;
      end
      S_POP2: begin
        if (sts_i.mode_dfs && sts_i.cur_visited) begin
          // stale stack entry: drop and retry
          cmd_o.pop_take = 1'b1;
          state_d = S_FETCH;
        end else begin
          cmd_o.pop_take = 1'b1;
          state_d = S_NBA;
        end
      end
      S_NBA: begin
        state_d = S_NBB; // adjacency read
      end
      S_NBB: begin
        state_d = S_NBC; // visited read of neighbour
      end
      S_NBC: begin
        if (sts_i.nb_last) begin
          done_o = 1'b1; use_cur_o = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.nb_take = 1'b1;
          state_d = S_NBA;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/graph_bfs_dfs_traversal.sv =====
// Top level: graph traversal engine (breadth-first / depth-first).
// Add edge: reads both end degrees, then rejects the edge or writes it into both lists; start:
// clears the visited memory in a sweep, mark by mark, then seeds the work store; fetch: pops a
// vertex and evaluates each neighbour's visited mark, skips stale stack entries, or finishes.
// One item at a time; busy is high until the result strobe. Results cannot be stalled.
// Reset is asynchronous active low; after it busy stays high while degrees clear.
module graph_bfs_dfs_traversal #(
  parameter int unsigned MAX_DEGREE   = 8,
  parameter int unsigned WORK_DEPTH   = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  gbt_pkg::req_t req_i,
  output logic          done_o,
  output gbt_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [10:0]   cfg_data_i
);
  import gbt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t dp_rsp;
  logic       done;
  logic [2:0] st;
  logic       use_cur;

  // controller sequences each item
  gbt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .req_type_i(req_i.req_type),
    .sts_i(sts), .busy_o(busy), .cmd_o(cmd), .done_o(done),
    .status_o(st), .use_cur_o(use_cur)
  );

  gbt_datapath #(
    .MAX_DEGREE(MAX_DEGREE), .WORK_DEPTH(WORK_DEPTH)
  ) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .sts_o(sts), .rsp_o(dp_rsp)
  );

  // result register: one cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= done;
  end

  always_ff @(posedge clk_i) begin
    if (done) rsp_o <= use_cur ? dp_rsp : rsp_t'{vertex: '0, status: st};
  end

  // a result is only raised while an item is in flight
  a_busy_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy) else $error("result without item in flight");
  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$past(done_o) || $past(start)) else $error("double strobe");
endmodule
